// ===== rtl/tgvs_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch gesture view selector package
// Shared types, register map and reset values for the view selector.
// ----------------------------------------------------------------------------
package tgvs_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 32;

    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    localparam logic [2:0] REG_CAMERA_COUNT  = 3'd0;
    localparam logic [2:0] REG_SWIPE_MIN_DX  = 3'd1;
    localparam logic [2:0] REG_SWIPE_MAX_DY  = 3'd2;
    localparam logic [2:0] REG_SWIPE_MAX_MS  = 3'd3;
    localparam logic [2:0] REG_TAP_MAX_DELTA = 3'd4;
    localparam logic [2:0] REG_SPLIT_COLUMN  = 3'd5;

    localparam logic [3:0]  RST_CAMERA_COUNT  = 4'd2;
    localparam logic [11:0] RST_SWIPE_MIN_DX  = 12'd100;
    localparam logic [11:0] RST_SWIPE_MAX_DY  = 12'd100;
    localparam logic [15:0] RST_SWIPE_MAX_MS  = 16'd500;
    localparam logic [11:0] RST_TAP_MAX_DELTA = 12'd50;
    localparam logic [11:0] RST_SPLIT_COLUMN  = 12'd640;

    localparam logic [3:0] MIN_DUAL_CAMERAS = 4'd2;
    localparam logic [3:0] ONE_CAMERA       = 4'd1;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_MOVE    = 2'd1,
        EV_RELEASE = 2'd2,
        EV_IGNORED = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        VIEW_DUAL   = 2'd0,
        VIEW_SINGLE = 2'd1,
        VIEW_AUTO   = 2'd2
    } t_view;

    typedef enum logic [1:0] {
        GEST_NONE  = 2'd0,
        GEST_SWIPE = 2'd1,
        GEST_TAP   = 2'd2
    } t_gesture;

    typedef struct packed {
        logic [3:0]  camera_count;
        logic [11:0] swipe_min_dx;
        logic [11:0] swipe_max_dy;
        logic [15:0] swipe_max_ms;
        logic [11:0] tap_max_delta;
        logic [11:0] split_column;
    } t_cfg;

    typedef struct packed {
        t_gesture gesture;
        t_view    view;
        logic     camera;
    } t_decision;

endpackage

// ===== rtl/tgvs_classify.sv =====
// ----------------------------------------------------------------------------
// Gesture classifier
// Classifies a release against its press and works out the next view.
// ----------------------------------------------------------------------------
module tgvs_classify import tgvs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  t_cfg                  i_cfg,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [TIME_BITS-1:0]  i_start_time,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  logic [TIME_BITS-1:0]  i_time,
    input  t_view                 i_view,
    input  logic                  i_camera,
    output t_decision             o_decision
);

    localparam int CW = (COORD_BITS > 12) ? COORD_BITS : 12;
    localparam int TW = (TIME_BITS > 16) ? TIME_BITS : 16;

    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [CW-1:0]         adx_w;
    logic [CW-1:0]         ady_w;
    logic [CW-1:0]         x_w;
    logic [TIME_BITS-1:0]  dur;
    logic [TW-1:0]         dur_w;
    logic                  right;
    logic                  left_half;
    logic                  is_swipe;
    logic                  is_tap;
    logic                  dual_ok;
    logic                  one_cam;

    assign adx   = (i_x >= i_start_x) ? (i_x - i_start_x) : (i_start_x - i_x);
    assign ady   = (i_y >= i_start_y) ? (i_y - i_start_y) : (i_start_y - i_y);
    assign adx_w = CW'(adx);
    assign ady_w = CW'(ady);
    assign x_w   = CW'(i_x);
    assign dur   = i_time - i_start_time;
    assign dur_w = TW'(dur);

    assign right     = i_x > i_start_x;
    assign left_half = x_w < CW'(i_cfg.split_column);
    assign is_swipe  = (adx_w > CW'(i_cfg.swipe_min_dx)) && (ady_w < CW'(i_cfg.swipe_max_dy))
                    && (dur_w < TW'(i_cfg.swipe_max_ms));
    assign is_tap    = (adx_w < CW'(i_cfg.tap_max_delta)) && (ady_w < CW'(i_cfg.tap_max_delta));
    assign dual_ok   = i_cfg.camera_count >= MIN_DUAL_CAMERAS;
    assign one_cam   = i_cfg.camera_count == ONE_CAMERA;

    always_comb begin
        o_decision.gesture = GEST_NONE;
        o_decision.view    = i_view;
        o_decision.camera  = i_camera;
        priority if (is_swipe) begin
            o_decision.gesture = GEST_SWIPE;
            priority if (dual_ok && i_view == VIEW_DUAL) begin
                o_decision.view   = VIEW_SINGLE;
                o_decision.camera = (right == left_half) ? 1'b0 : 1'b1;
            end else if (one_cam && i_view == VIEW_SINGLE) begin
                o_decision.view = right ? VIEW_AUTO : VIEW_SINGLE;
            end else if (i_view == VIEW_AUTO) begin
                o_decision.view = VIEW_SINGLE;
            end else begin
                o_decision.view = i_view;
            end
        end else if (is_tap) begin
            o_decision.gesture = GEST_TAP;
            priority if (dual_ok && i_view == VIEW_DUAL) begin
                o_decision.view   = VIEW_SINGLE;
                o_decision.camera = left_half ? 1'b0 : 1'b1;
            end else if (one_cam) begin
                o_decision.view = (i_view == VIEW_SINGLE) ? VIEW_AUTO : VIEW_SINGLE;
            end else begin
                o_decision.view = i_view;
            end
        end else begin
            o_decision.gesture = GEST_NONE;
        end
    end

endmodule

// ===== rtl/touch_gesture_view_selector.sv =====
// ----------------------------------------------------------------------------
// Touch gesture view selector
// Turns touch events into swipe and tap gestures that drive the camera view.
//
// The input channel carries one touch event per transfer (mode, x, y, time).
// Each event gives exactly one result transfer on the output channel with
// the view mode, the selected camera, the redraw flag and the gesture.
// An event is held in an input register, then classified and applied to
// the view state as it moves into the result register, from which its
// result is offered. One event can be accepted every cycle unless the
// receiver stalls; the rate is set by the single classify-and-update step
// between the two registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more event; the input stall rises only when
// both are full. Reset empties both registers, clears tracking and the
// start point, sets the view to dual with camera 0 and loads the default
// thresholds. Users must write registers through the APB-style port only
// while no event is in flight, which the block does not enforce; writing
// the camera count also resets the view to dual or single.
// ----------------------------------------------------------------------------
module touch_gesture_view_selector import tgvs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_mode,
    input  logic [COORD_BITS-1:0] i_touch_x,
    input  logic [COORD_BITS-1:0] i_touch_y,
    input  logic [TIME_BITS-1:0]  i_time_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_view_mode,
    output logic                  o_active_camera,
    output logic                  o_redraw,
    output logic [1:0]            o_gesture,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_AW-1:0]     paddr,
    input  logic [CFG_DW-1:0]     pwdata,
    output logic [CFG_DW-1:0]     prdata,
    output logic                  pready
);

    t_cfg                  r_cfg;
    logic                  r_in_valid;
    t_event                r_in_mode;
    logic [COORD_BITS-1:0] r_in_x;
    logic [COORD_BITS-1:0] r_in_y;
    logic [TIME_BITS-1:0]  r_in_time;
    logic                  r_tracking;
    logic [COORD_BITS-1:0] r_start_x;
    logic [COORD_BITS-1:0] r_start_y;
    logic [TIME_BITS-1:0]  r_start_time;
    t_view                 r_view;
    logic                  r_camera;
    logic                  r_out_valid;
    t_view                 r_out_view;
    logic                  r_out_camera;
    t_gesture              r_out_gesture;

    t_view                 n_view;
    logic                  n_camera;
    t_gesture              n_gesture;
    t_decision             decision;
    logic                  advance;
    logic                  in_take;
    logic                  cfg_write;
    logic [2:0]            reg_index;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign reg_index  = paddr[CFG_AW-1:2];

    tgvs_classify #(
        .COORD_BITS(COORD_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_classify (
        .i_cfg       (r_cfg),
        .i_start_x   (r_start_x),
        .i_start_y   (r_start_y),
        .i_start_time(r_start_time),
        .i_x         (r_in_x),
        .i_y         (r_in_y),
        .i_time      (r_in_time),
        .i_view      (r_view),
        .i_camera    (r_camera),
        .o_decision  (decision)
    );

    always_comb begin
        n_view    = r_view;
        n_camera  = r_camera;
        n_gesture = GEST_NONE;
        if (r_in_mode == EV_RELEASE && r_tracking) begin
            n_view    = decision.view;
            n_camera  = decision.camera;
            n_gesture = decision.gesture;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_index)
            REG_CAMERA_COUNT:  prdata = CFG_DW'(r_cfg.camera_count);
            REG_SWIPE_MIN_DX:  prdata = CFG_DW'(r_cfg.swipe_min_dx);
            REG_SWIPE_MAX_DY:  prdata = CFG_DW'(r_cfg.swipe_max_dy);
            REG_SWIPE_MAX_MS:  prdata = CFG_DW'(r_cfg.swipe_max_ms);
            REG_TAP_MAX_DELTA: prdata = CFG_DW'(r_cfg.tap_max_delta);
            REG_SPLIT_COLUMN:  prdata = CFG_DW'(r_cfg.split_column);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.camera_count  <= RST_CAMERA_COUNT;
            r_cfg.swipe_min_dx  <= RST_SWIPE_MIN_DX;
            r_cfg.swipe_max_dy  <= RST_SWIPE_MAX_DY;
            r_cfg.swipe_max_ms  <= RST_SWIPE_MAX_MS;
            r_cfg.tap_max_delta <= RST_TAP_MAX_DELTA;
            r_cfg.split_column  <= RST_SPLIT_COLUMN;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_CAMERA_COUNT:  r_cfg.camera_count  <= pwdata[3:0];
                REG_SWIPE_MIN_DX:  r_cfg.swipe_min_dx  <= pwdata[11:0];
                REG_SWIPE_MAX_DY:  r_cfg.swipe_max_dy  <= pwdata[11:0];
                REG_SWIPE_MAX_MS:  r_cfg.swipe_max_ms  <= pwdata[15:0];
                REG_TAP_MAX_DELTA: r_cfg.tap_max_delta <= pwdata[11:0];
                REG_SPLIT_COLUMN:  r_cfg.split_column  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode <= t_event'(i_mode);
            r_in_x    <= i_touch_x;
            r_in_y    <= i_touch_y;
            r_in_time <= i_time_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking   <= 1'b0;
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_start_time <= '0;
            r_view       <= VIEW_DUAL;
            r_camera     <= 1'b0;
        end else if (cfg_write && reg_index == REG_CAMERA_COUNT) begin
            r_view <= (pwdata[3:0] >= MIN_DUAL_CAMERAS) ? VIEW_DUAL : VIEW_SINGLE;
        end else if (advance) begin
            if (r_in_mode == EV_PRESS) begin
                r_tracking   <= 1'b1;
                r_start_x    <= r_in_x;
                r_start_y    <= r_in_y;
                r_start_time <= r_in_time;
            end else if (r_in_mode == EV_RELEASE) begin
                r_tracking <= 1'b0;
            end
            r_view   <= n_view;
            r_camera <= n_camera;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_view    <= n_view;
            r_out_camera  <= n_camera;
            r_out_gesture <= n_gesture;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_view_mode     = r_out_view;
    assign o_active_camera = r_out_camera;
    assign o_redraw        = r_out_gesture != GEST_NONE;
    assign o_gesture       = r_out_gesture;

endmodule

// ===== tb/sv/touch_gesture_view_selector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch gesture view selector testbench
// Drives touch events with bursty valid and a stalling receiver, and checks
// every result transfer against an in-bench model of the gesture classifier
// and view state. A directed script covers resets, wrap-around durations,
// every gesture path and register extremes; random phases with new register
// settings follow, made mostly of press, move and release sequences.
// ----------------------------------------------------------------------------
module touch_gesture_view_selector_tb import tgvs_pkg::*; ();

    localparam int CW          = COORD_BITS_DEF;
    localparam int TW          = TIME_BITS_DEF;
    localparam int COORD_MAX   = (1 << CW) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 4;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 150;

    localparam logic [2:0] REG_UNUSED = 3'd6;

    typedef struct packed {
        t_view    view;
        logic     camera;
        logic     redraw;
        t_gesture gesture;
    } t_view_result;

    typedef struct packed {
        logic         is_reg_write;
        logic [2:0]   reg_idx;
        logic [31:0]  reg_val;
        t_event       ev;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [TW-1:0] t;
        logic         typed;
        t_view_result want;
    } t_touch_row;

    localparam t_view_result AT_RESET = '{
        view: VIEW_DUAL, camera: 1'b0, redraw: 1'b0, gesture: GEST_NONE
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_mode = EV_MOVE;
    logic [CW-1:0]       i_touch_x = '0;
    logic [CW-1:0]       i_touch_y = '0;
    logic [TW-1:0]       i_time_ms = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [1:0]          o_view_mode;
    logic                o_active_camera;
    logic                o_redraw;
    logic [1:0]          o_gesture;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [CFG_AW-1:0]   paddr = '0;
    logic [CFG_DW-1:0]   pwdata = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    t_cfg          cfg;
    logic          trk;
    logic [CW-1:0] start_x;
    logic [CW-1:0] start_y;
    logic [TW-1:0] start_t;
    t_view         cur_view;
    logic          cur_cam;

    t_view_result view_results_due[$];
    t_view_result next_due;
    t_touch_row   touch_script[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           burst_left = 0;
    int           items_sent = 0;

    touch_gesture_view_selector DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_touch_x       (i_touch_x),
        .i_touch_y       (i_touch_y),
        .i_time_ms       (i_time_ms),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_view_mode     (o_view_mode),
        .o_active_camera (o_active_camera),
        .o_redraw        (o_redraw),
        .o_gesture       (o_gesture),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        case ((cycle_count / 300) % 4)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 9) < 3);
            2: i_out_stall <= ($urandom_range(0, 9) < 8);
            default: i_out_stall <= ((cycle_count % 7) < 3);
        endcase
    end

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h, cycle %0d",
                 field, got, want, cycle_count);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (view_results_due.size() == 0) begin
                report_mismatch("unexpected transfer", 32'({o_view_mode, o_gesture}), '0);
            end else begin
                next_due = view_results_due.pop_front();
                if (o_view_mode !== next_due.view)
                    report_mismatch("view_mode", 32'(o_view_mode), 32'(next_due.view));
                if (o_active_camera !== next_due.camera)
                    report_mismatch("active_camera", 32'(o_active_camera),
                                    32'(next_due.camera));
                if (o_redraw !== next_due.redraw)
                    report_mismatch("redraw", 32'(o_redraw), 32'(next_due.redraw));
                if (o_gesture !== next_due.gesture)
                    report_mismatch("gesture", 32'(o_gesture), 32'(next_due.gesture));
            end
        end
    end

    function automatic t_view_result classify_touch(t_event ev, logic [CW-1:0] x,
                                                    logic [CW-1:0] y, logic [TW-1:0] t);
        logic [CW-1:0] adx;
        logic [CW-1:0] ady;
        logic          right;
        logic          left_half;
        logic [TW-1:0] dur;
        t_view_result  r;
        r.gesture = GEST_NONE;
        if (ev == EV_PRESS) begin
            start_x = x;
            start_y = y;
            start_t = t;
            trk = 1'b1;
        end else if (ev == EV_RELEASE && trk) begin
            adx = (x >= start_x) ? x - start_x : start_x - x;
            ady = (y >= start_y) ? y - start_y : start_y - y;
            right = x > start_x;
            left_half = x < cfg.split_column;
            dur = t - start_t;
            trk = 1'b0;
            if (adx > cfg.swipe_min_dx && ady < cfg.swipe_max_dy
                && dur < TW'(cfg.swipe_max_ms)) begin
                r.gesture = GEST_SWIPE;
                if (cfg.camera_count >= MIN_DUAL_CAMERAS && cur_view == VIEW_DUAL) begin
                    cur_view = VIEW_SINGLE;
                    cur_cam = (right == left_half) ? 1'b0 : 1'b1;
                end else if (cfg.camera_count == ONE_CAMERA && cur_view == VIEW_SINGLE) begin
                    cur_view = right ? VIEW_AUTO : VIEW_SINGLE;
                end else if (cur_view == VIEW_AUTO) begin
                    cur_view = VIEW_SINGLE;
                end
            end else if (adx < cfg.tap_max_delta && ady < cfg.tap_max_delta) begin
                r.gesture = GEST_TAP;
                if (cfg.camera_count >= MIN_DUAL_CAMERAS && cur_view == VIEW_DUAL) begin
                    cur_view = VIEW_SINGLE;
                    cur_cam = left_half ? 1'b0 : 1'b1;
                end else if (cfg.camera_count == ONE_CAMERA) begin
                    cur_view = (cur_view == VIEW_SINGLE) ? VIEW_AUTO : VIEW_SINGLE;
                end
            end
        end
        r.view = cur_view;
        r.camera = cur_cam;
        r.redraw = (r.gesture != GEST_NONE);
        return r;
    endfunction

    function automatic void apply_reg_write(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_CAMERA_COUNT: begin
                cfg.camera_count = val[3:0];
                cur_view = (val[3:0] >= MIN_DUAL_CAMERAS) ? VIEW_DUAL : VIEW_SINGLE;
            end
            REG_SWIPE_MIN_DX:  cfg.swipe_min_dx = val[11:0];
            REG_SWIPE_MAX_DY:  cfg.swipe_max_dy = val[11:0];
            REG_SWIPE_MAX_MS:  cfg.swipe_max_ms = val[15:0];
            REG_TAP_MAX_DELTA: cfg.tap_max_delta = val[11:0];
            REG_SPLIT_COLUMN:  cfg.split_column = val[11:0];
            default: ;
        endcase
    endfunction

    task automatic send_event(t_event ev, logic [CW-1:0] x, logic [CW-1:0] y,
                              logic [TW-1:0] t, logic typed, t_view_result want);
        int           gap;
        t_view_result pred;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_mode <= ev;
        i_touch_x <= x;
        i_touch_y <= y;
        i_time_ms <= t;
        do @(posedge i_clk); while (o_in_stall);
        pred = classify_touch(ev, x, y, t);
        view_results_due.insert(view_results_due.size(), typed ? want : pred);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // Registers change only with no transfer in flight.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_in_valid <= 1'b0;
        while (view_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_reg_write(idx, val);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        burst_left = 0;
    endtask

    function automatic void add_touch(t_event ev, int x, int y, logic [TW-1:0] t,
                                      logic typed, t_view_result want);
        t_touch_row row;
        row = '0;
        row.ev = ev;
        row.x = CW'(x);
        row.y = CW'(y);
        row.t = t;
        row.typed = typed;
        row.want = want;
        touch_script.insert(touch_script.size(), row);
    endfunction

    function automatic void add_reg(logic [2:0] idx, logic [31:0] val);
        t_touch_row row;
        row = '0;
        row.is_reg_write = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        touch_script.insert(touch_script.size(), row);
    endfunction

    function automatic logic [31:0] rand_reg_value(logic [2:0] idx);
        int          pick;
        logic [31:0] top;
        pick = $urandom_range(0, 7);
        case (idx)
            REG_CAMERA_COUNT: top = 15;
            REG_SWIPE_MAX_MS: top = 65535;
            default:          top = COORD_MAX;
        endcase
        if (pick == 0)
            return '0;
        if (pick == 1)
            return top;
        case (idx)
            REG_CAMERA_COUNT:  return $urandom_range(0, 3);
            REG_SWIPE_MIN_DX:  return $urandom_range(0, 300);
            REG_SWIPE_MAX_DY:  return $urandom_range(20, 400);
            REG_SWIPE_MAX_MS:  return $urandom_range(50, 2000);
            REG_TAP_MAX_DELTA: return $urandom_range(0, 200);
            default:           return $urandom_range(0, COORD_MAX);
        endcase
    endfunction

    function automatic logic [CW-1:0] shift_coord(logic [CW-1:0] base, int unsigned mag);
        int v;
        if (mag > COORD_MAX)
            mag = COORD_MAX;
        v = $urandom_range(0, 1) ? int'(base) + int'(mag) : int'(base) - int'(mag);
        if (v > COORD_MAX)
            v = int'(base) - int'(mag);
        if (v < 0)
            v = int'(base) + int'(mag);
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < 0)
            v = 0;
        return CW'(v);
    endfunction

    // A press, up to two moves and usually a release aimed at a swipe, a tap or
    // anything at all; now and then the release is left out.
    task automatic gesture_sequence();
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic [TW-1:0] pt;
        int unsigned   dx;
        int unsigned   dy;
        int unsigned   dur;
        int            style;
        px = CW'($urandom_range(0, COORD_MAX));
        py = CW'($urandom_range(0, COORD_MAX));
        pt = TW'($urandom());
        send_event(EV_PRESS, px, py, pt, 1'b0, AT_RESET);
        repeat ($urandom_range(0, 2))
            send_event(EV_MOVE, CW'($urandom_range(0, COORD_MAX)),
                       CW'($urandom_range(0, COORD_MAX)),
                       pt + TW'($urandom_range(0, 300)), 1'b0, AT_RESET);
        style = $urandom_range(0, 9);
        if (style < 4) begin
            dx = cfg.swipe_min_dx + $urandom_range(1, 400);
            dy = $urandom_range(0, cfg.swipe_max_dy + 20);
            dur = $urandom_range(0, cfg.swipe_max_ms + 100);
        end else if (style < 7) begin
            dx = $urandom_range(0, cfg.tap_max_delta + 10);
            dy = $urandom_range(0, cfg.tap_max_delta + 10);
            dur = $urandom_range(0, 3000);
        end else begin
            dx = $urandom_range(0, COORD_MAX);
            dy = $urandom_range(0, COORD_MAX);
            dur = $urandom();
        end
        if (style != 9)
            send_event(EV_RELEASE, shift_coord(px, dx), shift_coord(py, dy),
                       pt + TW'(dur), 1'b0, AT_RESET);
    endtask

    initial begin
        int start_items;
        int phase;
        int r;
        cfg = '{RST_CAMERA_COUNT, RST_SWIPE_MIN_DX, RST_SWIPE_MAX_DY,
                RST_SWIPE_MAX_MS, RST_TAP_MAX_DELTA, RST_SPLIT_COLUMN};
        trk = 1'b0;
        start_x = '0;
        start_y = '0;
        start_t = '0;
        cur_view = VIEW_DUAL;
        cur_cam = 1'b0;

        add_touch(EV_RELEASE, 0, 0, 32'h0000_0000, 1'b1, AT_RESET);
        add_touch(EV_MOVE, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF, 1'b1, AT_RESET);
        add_touch(EV_IGNORED, COORD_MAX, 0, 32'h8000_0000, 1'b1, AT_RESET);
        add_touch(EV_PRESS, 100, 100, 32'hFFFF_FF00, 1'b1, AT_RESET);
        add_touch(EV_RELEASE, 300, 120, 32'h0000_0010, 1'b0, AT_RESET);
        add_reg(REG_CAMERA_COUNT, 2);
        add_touch(EV_PRESS, 1000, 200, 0, 1'b0, AT_RESET);
        add_touch(EV_RELEASE, 700, 200, 100, 1'b0, AT_RESET);
        add_touch(EV_PRESS, 10, 10, 5, 1'b0, AT_RESET);
        add_touch(EV_RELEASE, 40, 40, 5000, 1'b0, AT_RESET);
        add_reg(REG_CAMERA_COUNT, 1);
        add_touch(EV_PRESS, 0, 0, 0, 1'b0, AT_RESET);
        add_touch(EV_RELEASE, COORD_MAX, 0, 1, 1'b0, AT_RESET);
        add_touch(EV_PRESS, 500, 500, 0, 1'b0, AT_RESET);
        add_touch(EV_MOVE, 0, 0, 0, 1'b0, AT_RESET);
        add_touch(EV_RELEASE, 400, 500, 10, 1'b0, AT_RESET);
        add_touch(EV_PRESS, COORD_MAX, COORD_MAX, 0, 1'b0, AT_RESET);
        add_touch(EV_RELEASE, 0, COORD_MAX, 0, 1'b0, AT_RESET);
        add_touch(EV_PRESS, 100, 100, 0, 1'b0, AT_RESET);
        add_touch(EV_RELEASE, 100, 100, 0, 1'b0, AT_RESET);
        add_touch(EV_PRESS, 200, 200, 7, 1'b0, AT_RESET);
        add_touch(EV_RELEASE, 210, 190, 9, 1'b0, AT_RESET);
        add_reg(REG_CAMERA_COUNT, 0);
        add_reg(REG_TAP_MAX_DELTA, COORD_MAX);
        add_reg(REG_SWIPE_MIN_DX, 0);
        add_reg(REG_SWIPE_MAX_DY, COORD_MAX);
        add_reg(REG_SWIPE_MAX_MS, 65535);
        add_reg(REG_SPLIT_COLUMN, 0);
        add_reg(REG_UNUSED, 32'hFFFF_FFFF);
        add_touch(EV_PRESS, 5, 5, 0, 1'b0, AT_RESET);
        add_touch(EV_RELEASE, 6, 5, 1, 1'b0, AT_RESET);
        add_touch(EV_PRESS, 0, 0, 0, 1'b0, AT_RESET);
        add_touch(EV_RELEASE, 0, 0, 0, 1'b0, AT_RESET);
        add_reg(REG_CAMERA_COUNT, 15);
        add_reg(REG_SPLIT_COLUMN, COORD_MAX);
        add_touch(EV_PRESS, COORD_MAX, 3, 50, 1'b0, AT_RESET);
        add_touch(EV_RELEASE, COORD_MAX, 3, 60, 1'b0, AT_RESET);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (touch_script[i]) begin
            if (touch_script[i].is_reg_write)
                write_reg(touch_script[i].reg_idx, touch_script[i].reg_val);
            else
                send_event(touch_script[i].ev, touch_script[i].x, touch_script[i].y,
                           touch_script[i].t, touch_script[i].typed,
                           touch_script[i].want);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            for (r = REG_CAMERA_COUNT; r <= REG_SPLIT_COLUMN; r++)
                if (phase == 0 || $urandom_range(0, 2) != 0)
                    write_reg(3'(r), rand_reg_value(3'(r)));
            start_items = items_sent;
            while (items_sent - start_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 6) == 0)
                    send_event(t_event'($urandom_range(0, 3)),
                               CW'($urandom_range(0, COORD_MAX)),
                               CW'($urandom_range(0, COORD_MAX)),
                               TW'($urandom()), 1'b0, AT_RESET);
                else
                    gesture_sequence();
            end
        end

        i_in_valid <= 1'b0;
        while (view_results_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
